### src/mf2d_pkg.sv
// ----------------------------------------------------------------------------
// mf2d_pkg
// Types and constants shared by the 3x3 streaming median filter.
// ----------------------------------------------------------------------------
package mf2d_pkg;

  localparam int unsigned PixW    = 16;
  localparam int unsigned MaxCols = 1024;
  localparam int unsigned ColW    = $clog2(MaxCols);
  localparam int unsigned RowW    = 12;
  localparam int unsigned FifoDep = 2048;
  localparam int unsigned FifoAw  = $clog2(FifoDep);
  localparam int unsigned WinLen  = 9;
  localparam int unsigned CfgW    = 13;

  localparam logic [1:0] CFG_FRAME_COLUMNS = 2'd0;
  localparam logic [1:0] CFG_FRAME_ROWS    = 2'd1;
  localparam logic [1:0] CFG_SKIP_ZERO     = 2'd2;

  typedef struct packed {
    logic signed [PixW-1:0] pixel;
    logic                   flush;
  } pix_in_t;

  typedef struct packed {
    logic signed [PixW:0] value_x2;
    logic                 filtered;
    logic                 frame_end;
  } result_t;

endpackage

### src/median_filter_2d_window.sv
// ----------------------------------------------------------------------------
// median_filter_2d_window
// Streaming 3x3 median filter with optional zero skipping over raster pixels.
// ----------------------------------------------------------------------------
// Throughput is one word per cycle while the output is not stalled; a word
// that yields a result passes through the first-stage and output registers.
// A result leaves after clamped frame_columns + 1 further pixels, or is
// pushed out by flush words; the window is built from two line memories.
// Reset restores the register defaults and clears all counters; the line and
// pending-pixel memories are not cleared and need no clearing pass.
module median_filter_2d_window
  import mf2d_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  pix_in_t         in_data_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output result_t         out_data_o,
  input  logic            cfg_we_i,
  input  logic [1:0]      cfg_idx_i,
  input  logic [CfgW-1:0] cfg_wdata_i
);

  logic [10:0] frame_columns_q;
  logic [12:0] frame_rows_q;
  logic        skip_zero_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_columns_q <= 11'd64;
      frame_rows_q    <= 13'd64;
      skip_zero_q     <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_FRAME_COLUMNS: frame_columns_q <= cfg_wdata_i[10:0];
        CFG_FRAME_ROWS:    frame_rows_q    <= cfg_wdata_i;
        CFG_SKIP_ZERO:     skip_zero_q     <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  logic [10:0] cols;
  logic [12:0] rows;
  logic [10:0] delay;

  always_comb begin
    if (frame_columns_q < 11'd3) begin
      cols = 11'd3;
    end else if (frame_columns_q > 11'd1024) begin
      cols = 11'd1024;
    end else begin
      cols = frame_columns_q;
    end
    if (frame_rows_q < 13'd3) begin
      rows = 13'd3;
    end else if (frame_rows_q > 13'd4096) begin
      rows = 13'd4096;
    end else begin
      rows = frame_rows_q;
    end
    delay = cols + 11'd1;
  end

  logic              en;
  logic              acc;
  logic              is_pix;
  logic [FifoAw-1:0] wr_ptr_q, rd_ptr_q;
  logic [FifoAw-1:0] pending;
  logic [11:0]       pend_new;
  logic              emit;
  logic              geo;
  logic              interior;
  logic              fend;
  logic [ColW-1:0]   in_col_q, in_col_d;
  logic [ColW-1:0]   out_col_q, out_col_d;
  logic [RowW-1:0]   out_row_q, out_row_d;
  logic [10:0]       col_inc, ocol_inc;
  logic [12:0]       orow_inc;

  logic              out_valid_q;
  result_t           out_q;

  assign en         = !out_valid_q || !out_stall_i;
  assign in_stall_o = !en;
  assign acc        = in_valid_i && en;
  assign is_pix     = !in_data_i.flush;

  always_comb begin
    pending  = wr_ptr_q - rd_ptr_q;
    pend_new = {1'b0, pending} + {11'd0, is_pix};
    emit     = is_pix ? (pend_new > {1'b0, delay}) : (pending != '0);
    orow_inc = {1'b0, out_row_q} + 13'd1;
    ocol_inc = {1'b0, out_col_q} + 11'd1;
    col_inc  = {1'b0, in_col_q} + 11'd1;
    geo      = (out_row_q != '0) && (orow_inc < rows) &&
               (out_col_q != '0) && (ocol_inc < cols);
    interior = geo && is_pix && (pend_new == {1'b0, delay} + 12'd1);
    fend     = (orow_inc == rows) && (ocol_inc == cols);

    in_col_d = (col_inc >= cols) ? '0 : col_inc[ColW-1:0];
    if (ocol_inc >= cols) begin
      out_col_d = '0;
      out_row_d = (orow_inc >= rows) ? '0 : orow_inc[RowW-1:0];
    end else begin
      out_col_d = ocol_inc[ColW-1:0];
      out_row_d = out_row_q;
    end
  end

  // First stage: the taken word with its line and pending memory reads.
  logic                   s1_vld_q, s1_pix_q, s1_emit_q, s1_int_q, s1_fend_q;
  logic signed [PixW-1:0] s1_pixel_q;
  logic [ColW-1:0]        s1_ptr_q;
  logic signed [PixW-1:0] rd_a_q, rd_b_q, rd_c_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q  <= '0;
      rd_ptr_q  <= '0;
      in_col_q  <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
      s1_vld_q  <= 1'b0;
      s1_pix_q  <= 1'b0;
      s1_emit_q <= 1'b0;
      s1_int_q  <= 1'b0;
      s1_fend_q <= 1'b0;
    end else if (en) begin
      s1_vld_q  <= acc;
      s1_pix_q  <= acc && is_pix;
      s1_emit_q <= acc && emit;
      s1_int_q  <= acc && emit && interior;
      s1_fend_q <= fend;
      if (acc && is_pix) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
        in_col_q <= in_col_d;
      end
      if (acc && emit) begin
        rd_ptr_q  <= rd_ptr_q + 1'b1;
        out_col_q <= out_col_d;
        out_row_q <= out_row_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_pixel_q <= in_data_i.pixel;
      s1_ptr_q   <= in_col_q;
    end
  end

  logic signed [PixW-1:0] line_a_mem [MaxCols];
  logic signed [PixW-1:0] line_b_mem [MaxCols];
  logic signed [PixW-1:0] pend_mem   [FifoDep];

  always_ff @(posedge clk_i) begin
    if (en) begin
      rd_a_q <= line_a_mem[in_col_q];
      rd_b_q <= line_b_mem[in_col_q];
      if (s1_pix_q) begin
        line_a_mem[s1_ptr_q] <= s1_pixel_q;
        line_b_mem[s1_ptr_q] <= rd_a_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc && is_pix) begin
      pend_mem[wr_ptr_q] <= in_data_i.pixel;
    end
    if (acc && emit) begin
      rd_c_q <= pend_mem[rd_ptr_q];
    end
  end

  // Window: column one and two hold older columns, the newest comes from
  // the first stage.
  logic signed [PixW-1:0] win_q [6];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 6; i++) begin
        win_q[i] <= '0;
      end
    end else if (en && s1_pix_q) begin
      win_q[0] <= s1_pixel_q;
      win_q[1] <= rd_a_q;
      win_q[2] <= rd_b_q;
      win_q[3] <= win_q[0];
      win_q[4] <= win_q[1];
      win_q[5] <= win_q[2];
    end
  end

  logic signed [PixW-1:0] wv [WinLen];
  logic                   wx [WinLen];
  logic [3:0]             rank [WinLen];
  logic [3:0]             cnt;
  logic [3:0]             hi_r, lo_r;
  logic signed [PixW-1:0] v_hi, v_lo;
  logic signed [PixW:0]   med_x2;
  logic                   filt;
  result_t                res;

  function automatic logic less(input logic signed [PixW-1:0] a, input logic ea,
                                input logic signed [PixW-1:0] b, input logic eb);
    logic r;
    if (ea != eb) begin
      r = eb;
    end else begin
      r = a < b;
    end
    return r;
  endfunction

  always_comb begin
    wv[0] = s1_pixel_q;
    wv[1] = rd_a_q;
    wv[2] = rd_b_q;
    for (int i = 0; i < 6; i++) begin
      wv[i+3] = win_q[i];
    end
    cnt = '0;
    for (int i = 0; i < WinLen; i++) begin
      wx[i] = skip_zero_q && (wv[i] == '0);
      cnt   = cnt + {3'd0, !wx[i]};
    end
    for (int i = 0; i < WinLen; i++) begin
      rank[i] = '0;
      for (int j = 0; j < WinLen; j++) begin
        if (j != i) begin
          if (less(wv[j], wx[j], wv[i], wx[i]) ||
              (!less(wv[i], wx[i], wv[j], wx[j]) && j < i)) begin
            rank[i] = rank[i] + 4'd1;
          end
        end
      end
    end
    hi_r = cnt >> 1;
    lo_r = cnt[0] ? hi_r : hi_r - 4'd1;
    v_hi = '0;
    v_lo = '0;
    for (int i = 0; i < WinLen; i++) begin
      if (rank[i] == hi_r) begin
        v_hi = v_hi | wv[i];
      end
      if (rank[i] == lo_r) begin
        v_lo = v_lo | wv[i];
      end
    end
    med_x2 = {v_hi[PixW-1], v_hi} + {v_lo[PixW-1], v_lo};
    filt   = s1_int_q && (cnt >= 4'd4);
    res.value_x2  = filt ? med_x2 : {rd_c_q, 1'b0};
    res.filtered  = filt;
    res.frame_end = s1_fend_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= s1_vld_q && s1_emit_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_int_is_pixel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_int_q |-> (s1_pix_q && s1_emit_q && s1_vld_q))
    else $error("interior result without a pixel word");

  a_frame_end_border: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.frame_end) |-> !out_data_o.filtered)
    else $error("last pixel of a slice was filtered");

  a_stall_needs_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_q)
    else $error("input stalled with an empty output register");

endmodule

### verif/median_filter_2d_window_tb.sv
// ----------------------------------------------------------------------------
// median_filter_2d_window_tb
// Self-checking testbench for the streaming 3x3 median filter.
// ----------------------------------------------------------------------------
// Whole image slices of random pixels, with flush words mixed in, are sent
// through the filter under several frame sizes and both zero-skipping modes.
// A behavioural model predicts every result word, and the monitor compares
// each one field by field. Both sides idle and stall at random.
module median_filter_2d_window_tb;
  import mf2d_pkg::*;

  localparam int unsigned HistDepth = 2 * (MaxCols + 1) + 1;
  localparam int unsigned IdleLimit = 5000;

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            in_valid = 1'b0;
  logic            in_stall;
  pix_in_t         in_data = '0;
  logic            out_valid;
  logic            out_stall = 1'b0;
  result_t         out_data;
  logic            cfg_we = 1'b0;
  logic [1:0]      cfg_idx = CFG_FRAME_COLUMNS;
  logic [CfgW-1:0] cfg_wdata = '0;

  pix_in_t pixel_queue[$];
  result_t expected_results[$];
  int      sender_gap_pct = 0;
  int      receiver_stall_pct = 0;
  int      error_count = 0;
  int      idle_cycles = 0;

  // Model state.
  int      hist[HistDepth];
  int      hist_wp = 0;
  int      backlog = 0;
  int      in_r = 0, in_c = 0, out_r = 0, out_c = 0;
  int      cfg_cols = 64, cfg_rows = 64;
  bit      cfg_skip = 1'b1;

  median_filter_2d_window i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata)
  );

  always #5 clk_i = ~clk_i;

  function automatic int eff_cols();
    return (cfg_cols < 3) ? 3 : (cfg_cols > MaxCols) ? MaxCols : cfg_cols;
  endfunction

  function automatic int eff_rows();
    return (cfg_rows < 3) ? 3 : (cfg_rows > 4096) ? 4096 : cfg_rows;
  endfunction

  function automatic int hist_at(int age);
    return hist[(hist_wp + HistDepth - 1 - age) % HistDepth];
  endfunction

  task automatic step_pos(ref int r, ref int c, input int rows, input int cols);
    c++;
    if (c >= cols) begin
      c = 0;
      r++;
      if (r >= rows) r = 0;
    end
  endtask

  task automatic median_predict(input pix_in_t w);
    int      cols, rows, dly, ctr, n, key, j;
    int      win[WinLen];
    int      v;
    longint  res;
    bit      inner;
    result_t r;
    cols = eff_cols();
    rows = eff_rows();
    dly  = cols + 1;
    n    = 0;
    if (!w.flush) begin
      hist[hist_wp] = int'(w.pixel);
      hist_wp = (hist_wp + 1) % HistDepth;
      if (backlog < HistDepth) backlog++;
      step_pos(in_r, in_c, rows, cols);
      if (backlog <= dly) return;
    end else if (backlog == 0) begin
      return;
    end
    ctr = backlog - 1;
    res = 2 * hist_at(ctr);
    r.filtered = 1'b0;
    inner = out_r >= 1 && out_r + 1 < rows && out_c >= 1 && out_c + 1 < cols &&
            ctr >= dly && ctr + dly < HistDepth;
    if (inner) begin
      for (int dr = -1; dr <= 1; dr++) begin
        for (int dc = -1; dc <= 1; dc++) begin
          v = hist_at(ctr - dr * cols - dc);
          if (!(cfg_skip && v == 0)) begin
            win[n] = v;
            n++;
          end
        end
      end
      if (n >= WinLen / 2 && n > 0) begin
        for (int i = 1; i < n; i++) begin
          key = win[i];
          j = i;
          while (j > 0 && win[j-1] > key) begin
            win[j] = win[j-1];
            j--;
          end
          win[j] = key;
        end
        if (n % 2) res = 2 * win[n/2];
        else res = win[n/2-1] + win[n/2];
        r.filtered = 1'b1;
      end
    end
    r.value_x2  = res[PixW:0];
    r.frame_end = (out_r + 1 == rows && out_c + 1 == cols);
    expected_results.push_back(r);
    backlog--;
    step_pos(out_r, out_c, rows, cols);
  endtask

  task automatic report_mismatch(input string what, input int got, input int exp);
    $display("mismatch in %s: got %0d, expected %0d at %0t", what, got, exp, $realtime);
    error_count++;
  endtask

  // Driver.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && !in_stall) median_predict(in_data);
      if (!(in_valid && in_stall)) begin
        if (pixel_queue.size() != 0 && $urandom_range(99) >= sender_gap_pct) begin
          in_valid <= 1'b1;
          in_data  <= pixel_queue.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor.
  always @(posedge clk_i) begin
    result_t e;
    if (rst_ni) begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result count", 1, 0);
        end else begin
          e = expected_results.pop_front();
          if (out_data.value_x2 !== e.value_x2)
            report_mismatch("value_x2", int'(out_data.value_x2), int'(e.value_x2));
          if (out_data.filtered !== e.filtered)
            report_mismatch("filtered", int'(out_data.filtered), int'(e.filtered));
          if (out_data.frame_end !== e.frame_end)
            report_mismatch("frame_end", int'(out_data.frame_end), int'(e.frame_end));
        end
      end
      out_stall <= ($urandom_range(99) < receiver_stall_pct);
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
        (pixel_queue.size() == 0 && !in_valid && expected_results.size() == 0)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  task automatic cfg_write(input logic [1:0] idx, input int val);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val[CfgW-1:0];
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    case (idx)
      CFG_FRAME_COLUMNS: cfg_cols = val & 'h7FF;
      CFG_FRAME_ROWS:    cfg_rows = val & 'h1FFF;
      default:           cfg_skip = val[0];
    endcase
  endtask

  task automatic wait_drained();
    while (pixel_queue.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  function automatic pix_in_t make_word(bit fl, int pix);
    pix_in_t w;
    w.flush = fl;
    w.pixel = pix[PixW-1:0];
    return w;
  endfunction

  function automatic int rand_pixel();
    case ($urandom_range(9))
      0, 1, 2: return 0;
      3:       return ($urandom_range(1)) ? 32767 : -32768;
      4, 5:    return $urandom_range(20) - 10;
      default: return int'($signed(16'($urandom())));
    endcase
  endfunction

  task automatic queue_slices(int count, int flush_pct);
    int total;
    total = eff_cols() * eff_rows() * count;
    for (int i = 0; i < total; i++) begin
      if ($urandom_range(99) < flush_pct)
        pixel_queue.push_back(make_word(1'b1, $urandom()));
      pixel_queue.push_back(make_word(1'b0, rand_pixel()));
    end
    for (int i = 0; i < eff_cols() + 1; i++)
      pixel_queue.push_back(make_word(1'b1, $urandom()));
  endtask

  initial begin
    int sent;
    int dir_pix[9] = '{32767, -32768, 0, 5, 0, -1, 32767, 0, -32768};
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    cfg_write(CFG_FRAME_COLUMNS, 3);
    cfg_write(CFG_FRAME_ROWS, 3);
    cfg_write(CFG_SKIP_ZERO, 1);
    // Flushes with nothing pending, one slice, then an early flush drain.
    pixel_queue.push_back(make_word(1'b1, 0));
    pixel_queue.push_back(make_word(1'b1, -1));
    foreach (dir_pix[i]) pixel_queue.push_back(make_word(1'b0, dir_pix[i]));
    repeat (6) pixel_queue.push_back(make_word(1'b1, 0));
    wait_drained();
    cfg_write(CFG_SKIP_ZERO, 0);
    foreach (dir_pix[i]) pixel_queue.push_back(make_word(1'b0, dir_pix[i]));
    for (int i = 0; i < 9; i++) pixel_queue.push_back(make_word(1'b0, 0));
    repeat (4) pixel_queue.push_back(make_word(1'b1, 0));
    wait_drained();

    sent = 0;
    for (int ph = 0; sent < 850; ph++) begin
      if (sent < 280) begin
        sender_gap_pct = 12;
        receiver_stall_pct = 72;
      end else if (sent < 560) begin
        sender_gap_pct = 72;
        receiver_stall_pct = 12;
      end else begin
        sender_gap_pct = 0;
        receiver_stall_pct = 0;
      end
      cfg_write(CFG_FRAME_COLUMNS, (ph % 5 == 0) ? 0 : $urandom_range(3, 9));
      cfg_write(CFG_FRAME_ROWS, (ph % 7 == 0) ? 0 : $urandom_range(3, 7));
      cfg_write(CFG_SKIP_ZERO, $urandom_range(1));
      sent += pixel_queue.size();
      queue_slices($urandom_range(1, 3), (ph % 3 == 0) ? 0 : 6);
      sent = sent + pixel_queue.size();
      wait_drained();
    end

    // Out-of-range sizes saturate to the widest row and the tallest slice;
    // the run ends partway through that slice.
    cfg_write(CFG_FRAME_COLUMNS, 2047);
    cfg_write(CFG_FRAME_ROWS, 8191);
    cfg_write(CFG_SKIP_ZERO, 0);
    for (int i = 0; i < MaxCols + 16; i++)
      pixel_queue.push_back(make_word(1'b0, rand_pixel()));
    wait_drained();
    repeat (20) @(posedge clk_i);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### median_filter_2d_window.f
src/mf2d_pkg.sv
src/median_filter_2d_window.sv
verif/median_filter_2d_window_tb.sv
